[hdl/assc_pkg.sv]
package assc_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 1024;

  localparam int unsigned TIME_W      = 32;
  localparam int unsigned FUNC_W      = 3;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned Q_FRAC      = 8;
  localparam int unsigned RATE_W      = 50;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_BITS    = 150;
  localparam int unsigned OUT_TDATA_W = 152;

  localparam logic [TIME_W-1:0] MS_PER_S = 32'd1000;

  // x / 1000 == (x * RECIP_1000) >> RECIP_SHIFT for every 32-bit x
  localparam int unsigned RECIP_W     = 29;
  localparam int unsigned RECIP_SHIFT = 38;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 29'd274877907;

  localparam logic [31:0] THR_RST      = 32'd256;
  localparam logic [31:0] MIN_SLEEP_RST = 32'd60000;
  localparam logic [31:0] WINDOW_RST   = 32'd60000;
  localparam logic [31:0] INTERVAL_RST = 32'd300000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_THR   = 3'd0,
    CFG_MIN_SLEEP = 3'd1,
    CFG_WINDOW    = 3'd2,
    CFG_INTERVAL  = 3'd3,
    CFG_AUTO_EN   = 3'd4
  } cfg_idx_e;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD_OPS     = 3'd0,
    FUNC_EVAL        = 3'd1,
    FUNC_FORCE_SLEEP = 3'd2,
    FUNC_WAKE        = 3'd3,
    FUNC_CONS_DONE   = 3'd4,
    FUNC_CLEAR       = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    ACT_ACTIVE = 2'd0,
    ACT_LOW    = 2'd1,
    ACT_SLEEP  = 2'd2
  } act_state_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_SCAN,
    SEQ_SPAN,
    SEQ_RATE,
    SEQ_FINISH
  } seq_state_e;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

endpackage

[hdl/activity_sleep_state_controller_unit.sv]
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser func, tdata now_ms, op_count
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata result word, 150 bits used
// cfg       in   cfg_we_i                       cfg_idx_i, cfg_data_i, no read-back
//
// a non-evaluate word is applied and its result registered when it is accepted; an evaluate
// offers its result after one history memory read per entry, a reciprocal multiply for
// whole seconds, then DIV_W one-bit divider steps for the Q8 rate (the divider is skipped
// when the span is under a second); no new word is taken while an evaluate runs
// reset clears all control state; the history store uses a fill count, no clearing pass
// a stalled result sits in the output register; a new word is taken in the cycle it leaves
module activity_sleep_state_controller_unit #(
  parameter int unsigned HISTORY_DEPTH = assc_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [assc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [assc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // now_ms [31:0], op_count [63:32]
  input  logic [assc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // func [2:0]
  input  logic [assc_pkg::FUNC_W-1:0]        s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // activity_state [1:0], state_changed [2], rate_q8 [52:3], consolidation_due [53],
  // sleep_periods [85:54], sleep_seconds_total [117:86], consolidation_cycles [149:118]
  output logic [assc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import assc_pkg::*;

  localparam int unsigned AW    = $clog2(HISTORY_DEPTH);
  localparam int unsigned FW    = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SUM_W = TIME_W + AW;
  localparam int unsigned DIV_W = SUM_W + Q_FRAC;
  localparam int unsigned CNT_W = $clog2(DIV_W + 1);
  localparam int unsigned PROD_W = TIME_W + RECIP_W;
  localparam logic [AW-1:0] HEAD_LAST = AW'(HISTORY_DEPTH - 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(HISTORY_DEPTH);

  // configuration
  logic [TIME_W-1:0] thr_q, min_sleep_q, window_q, interval_q;
  logic              auto_en_q;

  // sequencer and history
  seq_state_e          seq_q, seq_d;
  logic [AW-1:0]       head_q, head_d;
  logic [FW-1:0]       fill_q, fill_d;
  logic [TIME_W-1:0]   pend_q, pend_d;
  logic [TIME_W-1:0]   now_q, now_d;
  logic [FW-1:0]       rd_idx_q, rd_idx_d;
  logic                rd_vld_q, rd_vld_d;
  logic [2*TIME_W-1:0] rd_data_q;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [TIME_W-1:0]   span_q, span_d;
  logic [DIV_W-1:0]    dvd_q, dvd_d;
  logic [TIME_W-1:0]   rem_q, rem_d;
  logic [TIME_W-1:0]   dsr_q, dsr_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [2*TIME_W-1:0] hist_mem [HISTORY_DEPTH];

  // activity control
  act_state_e        act_q, act_d;
  logic [TIME_W-1:0] entry_q, entry_d;
  logic [TIME_W-1:0] last_cons_q, last_cons_d;
  logic [TIME_W-1:0] periods_q, periods_d;
  logic [TIME_W-1:0] sleep_secs_q, sleep_secs_d;
  logic [TIME_W-1:0] cons_cnt_q, cons_cnt_d;

  logic                   out_vld_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  logic              in_acc, in_eval, push, fin, apply, out_free, rd_en;
  logic [TIME_W-1:0] in_now, in_ops, age;
  logic [TIME_W:0]   rem_sh;
  logic              div_ge;
  logic [PROD_W-1:0] span_prod;
  logic [TIME_W-1:0] span_s;
  logic [FUNC_W-1:0] cmd_func;
  logic [TIME_W-1:0] cmd_now, slept, slept_s;
  logic [PROD_W-1:0] slept_prod;
  logic              low, leave, changed, due;

  assign in_now   = s_axis_tdata[TIME_W-1:0];
  assign in_ops   = s_axis_tdata[2*TIME_W-1:TIME_W];
  assign out_free = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (seq_q == SEQ_IDLE) && out_free;
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_eval  = (s_axis_tuser == FUNC_EVAL);
  assign push     = in_acc && in_eval;
  assign fin      = (seq_q == SEQ_FINISH) && out_free;
  assign apply    = (in_acc && !in_eval) || fin;
  assign rd_en    = (seq_q == SEQ_SCAN) && (rd_idx_q != fill_q);

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= THR_RST;
      min_sleep_q <= MIN_SLEEP_RST;
      window_q    <= WINDOW_RST;
      interval_q  <= INTERVAL_RST;
      auto_en_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LOW_THR:   thr_q       <= cfg_data_i;
        CFG_MIN_SLEEP: min_sleep_q <= cfg_data_i;
        CFG_WINDOW:    window_q    <= cfg_data_i;
        CFG_INTERVAL:  interval_q  <= cfg_data_i;
        CFG_AUTO_EN:   auto_en_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // whole seconds of the span
  assign span_prod = PROD_W'(span_q) * PROD_W'(RECIP_1000);
  assign span_s    = TIME_W'(span_prod[PROD_W-1:RECIP_SHIFT]);

  // next state
  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      SEQ_IDLE:   if (push) seq_d = SEQ_SCAN;
      SEQ_SCAN:   if (rd_idx_q == fill_q) seq_d = SEQ_SPAN;
      SEQ_SPAN:   seq_d = (span_s == '0) ? SEQ_FINISH : SEQ_RATE;
      SEQ_RATE:   if (cnt_q == CNT_W'(DIV_W - 1)) seq_d = SEQ_FINISH;
      SEQ_FINISH: if (out_free) seq_d = SEQ_IDLE;
      default:    seq_d = SEQ_IDLE;
    endcase
  end

  // restoring divider step
  assign rem_sh = {rem_q, dvd_q[DIV_W-1]};
  assign div_ge = (rem_sh >= {1'b0, dsr_q});
  assign age    = now_q - rd_data_q[TIME_W-1:0];

  // sequencer datapath
  always_comb begin
    head_d   = head_q;
    fill_d   = fill_q;
    pend_d   = pend_q;
    now_d    = now_q;
    rd_idx_d = rd_idx_q;
    rd_vld_d = 1'b0;
    sum_d    = sum_q;
    span_d   = span_q;
    dvd_d    = dvd_q;
    rem_d    = rem_q;
    dsr_d    = dsr_q;
    cnt_d    = cnt_q;
    if (in_acc && (s_axis_tuser == FUNC_ADD_OPS)) begin
      pend_d = sat_add(pend_q, in_ops);
    end
    if (push) begin
      head_d   = (head_q == HEAD_LAST) ? '0 : head_q + AW'(1);
      fill_d   = (fill_q == FILL_FULL) ? fill_q : fill_q + FW'(1);
      pend_d   = '0;
      now_d    = in_now;
      rd_idx_d = '0;
      sum_d    = '0;
      span_d   = '0;
    end
    case (seq_q)
      SEQ_SCAN: begin
        rd_vld_d = rd_en;
        if (rd_en) begin
          rd_idx_d = rd_idx_q + FW'(1);
        end
        if (rd_vld_q && (age <= window_q)) begin
          sum_d = sum_q + SUM_W'(rd_data_q[2*TIME_W-1:TIME_W]);
          if (age > span_q) begin
            span_d = age;
          end
        end
      end
      SEQ_SPAN: begin
        if (span_s == '0) begin
          dvd_d = '0;
        end else begin
          dvd_d = {sum_q, {Q_FRAC{1'b0}}};
          dsr_d = span_s;
        end
        rem_d = '0;
        cnt_d = '0;
      end
      SEQ_RATE: begin
        rem_d = div_ge ? TIME_W'(rem_sh - {1'b0, dsr_q}) : TIME_W'(rem_sh);
        dvd_d = {dvd_q[DIV_W-2:0], div_ge};
        cnt_d = cnt_q + CNT_W'(1);
      end
      default: ;
    endcase
  end

  // command decode, shared by non-evaluate words and the end of an evaluate
  assign cmd_func   = fin ? FUNC_EVAL : s_axis_tuser;
  assign cmd_now    = fin ? now_q : in_now;
  assign low        = (dvd_q < DIV_W'(thr_q));
  assign slept      = cmd_now - entry_q;
  assign slept_prod = PROD_W'(slept) * PROD_W'(RECIP_1000);
  assign slept_s    = TIME_W'(slept_prod[PROD_W-1:RECIP_SHIFT]);

  always_comb begin
    act_d        = act_q;
    entry_d      = entry_q;
    last_cons_d  = last_cons_q;
    periods_d    = periods_q;
    sleep_secs_d = sleep_secs_q;
    cons_cnt_d   = cons_cnt_q;
    leave        = 1'b0;
    unique case (cmd_func)
      FUNC_EVAL: begin
        case (act_q)
          ACT_ACTIVE: begin
            if (low) begin
              act_d   = ACT_LOW;
              entry_d = cmd_now;
            end
          end
          ACT_LOW: begin
            if (!low) begin
              act_d   = ACT_ACTIVE;
              entry_d = cmd_now;
            end else if (slept >= min_sleep_q) begin
              act_d   = ACT_SLEEP;
              entry_d = cmd_now;
            end
          end
          default: leave = !low;
        endcase
      end
      FUNC_FORCE_SLEEP: begin
        act_d   = ACT_SLEEP;
        entry_d = cmd_now;
      end
      FUNC_WAKE: leave = (act_q == ACT_SLEEP);
      FUNC_CONS_DONE: begin
        last_cons_d = cmd_now;
        cons_cnt_d  = sat_add(cons_cnt_q, TIME_W'(1));
      end
      FUNC_CLEAR: begin
        periods_d    = '0;
        sleep_secs_d = '0;
        cons_cnt_d   = '0;
      end
      default: ;
    endcase
    if (leave) begin
      act_d        = ACT_ACTIVE;
      entry_d      = cmd_now;
      periods_d    = sat_add(periods_q, TIME_W'(1));
      sleep_secs_d = sat_add(sleep_secs_q, slept_s);
    end
  end

  assign changed = fin && (act_d != act_q);
  assign due     = auto_en_q && (act_d == ACT_SLEEP) &&
                   ((cmd_now - last_cons_d) >= interval_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q        <= SEQ_IDLE;
      head_q       <= '0;
      fill_q       <= '0;
      pend_q       <= '0;
      rd_idx_q     <= '0;
      rd_vld_q     <= 1'b0;
      act_q        <= ACT_ACTIVE;
      entry_q      <= '0;
      last_cons_q  <= '0;
      periods_q    <= '0;
      sleep_secs_q <= '0;
      cons_cnt_q   <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      seq_q    <= seq_d;
      head_q   <= head_d;
      fill_q   <= fill_d;
      pend_q   <= pend_d;
      rd_idx_q <= rd_idx_d;
      rd_vld_q <= rd_vld_d;
      if (apply) begin
        act_q        <= act_d;
        entry_q      <= entry_d;
        last_cons_q  <= last_cons_d;
        periods_q    <= periods_d;
        sleep_secs_q <= sleep_secs_d;
        cons_cnt_q   <= cons_cnt_d;
        out_vld_q    <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    now_q  <= now_d;
    sum_q  <= sum_d;
    span_q <= span_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    cnt_q  <= cnt_d;
    if (apply) begin
      out_data_q <= {{(OUT_TDATA_W - OUT_BITS){1'b0}}, cons_cnt_d, sleep_secs_d, periods_d,
                     due, (fin ? RATE_W'(dvd_q) : {RATE_W{1'b0}}), changed, act_d};
    end
  end

  // history memory
  always_ff @(posedge clk_i) begin
    if (push) begin
      hist_mem[head_q] <= {pend_q, in_now};
    end
    if (rd_en) begin
      rd_data_q <= hist_mem[rd_idx_q[AW-1:0]];
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_FULL)
    else $error("history fill count beyond depth");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SEQ_SCAN) |-> (rd_idx_q <= fill_q))
    else $error("scan index passed fill count");

  a_push_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> ((seq_q == SEQ_SCAN) && (fill_q != '0)))
    else $error("evaluate did not start a scan of a non-empty history");

  a_rate_dsr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SEQ_RATE) |-> (dsr_q != '0))
    else $error("rate division by zero seconds");

  a_finish_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |=> (out_vld_q && (seq_q == SEQ_IDLE)))
    else $error("finished evaluate did not load a result word");

endmodule

[sim/activity_sleep_checker.sv]
`timescale 1ns / 100ps
module activity_sleep_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [assc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [assc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               s_axis_tvalid,
  input  logic                               s_axis_tready,
  // now_ms [31:0], op_count [63:32]
  input  logic [assc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // func [2:0]
  input  logic [assc_pkg::FUNC_W-1:0]        s_axis_tuser,
  input  logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // activity_state [1:0], state_changed [2], rate_q8 [52:3], consolidation_due [53],
  // sleep_periods [85:54], sleep_seconds_total [117:86], consolidation_cycles [149:118]
  input  logic [assc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output int unsigned                        fail_count_o,
  output int unsigned                        pending_o
);
  import assc_pkg::*;

  localparam int unsigned HIST_DEPTH   = HISTORY_DEPTH_DEF;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [31:0]       cons_cycles;
    logic [31:0]       sleep_secs;
    logic [31:0]       sleep_periods;
    logic              due;
    logic [RATE_W-1:0] rate;
    logic              changed;
    act_state_e        state;
  } status_word_t;

  logic [31:0] low_thr;
  logic [31:0] min_sleep;
  logic [31:0] window;
  logic [31:0] interval;
  logic        auto_en;

  logic [31:0] hist_time [HIST_DEPTH];
  logic [31:0] hist_ops  [HIST_DEPTH];
  int unsigned hist_head;
  int unsigned hist_fill;

  logic [31:0] pending_ops;
  act_state_e  cur_state;
  logic [31:0] entry_time;
  logic [31:0] last_cons;
  logic [31:0] periods;
  logic [31:0] slept_s;
  logic [31:0] cons_done;

  status_word_t status_queue [$];
  status_word_t got;
  status_word_t want;
  status_word_t predicted;

  function automatic logic [31:0] add_sat32(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] s;
    s = a + b;
    return (s < a) ? 32'hFFFF_FFFF : s;
  endfunction

  function automatic logic [RATE_W-1:0] window_rate(input logic [31:0] now);
    logic [63:0] total;
    logic [31:0] span;
    logic [31:0] age;
    logic [31:0] secs;
    logic [63:0] q;
    total = '0;
    span  = '0;
    for (int unsigned i = 0; i < hist_fill; i++) begin
      age = now - hist_time[i];
      if (age <= window) begin
        total += {32'd0, hist_ops[i]};
        if (age > span) span = age;
      end
    end
    secs = span / MS_PER_S;
    if (secs == 32'd0) return '0;
    q = (total << Q_FRAC) / {32'd0, secs};
    return q[RATE_W-1:0];
  endfunction

  function automatic void end_sleep(input logic [31:0] now);
    logic [31:0] secs;
    secs       = (now - entry_time) / MS_PER_S;
    cur_state  = ACT_ACTIVE;
    entry_time = now;
    periods    = add_sat32(periods, 32'd1);
    slept_s    = add_sat32(slept_s, secs);
  endfunction

  function automatic status_word_t apply_command(input logic [FUNC_W-1:0] f,
                                                 input logic [31:0] now,
                                                 input logic [31:0] ops);
    status_word_t w;
    act_state_e   prior;
    logic [RATE_W-1:0] rate;
    logic [31:0]  in_state;
    logic [31:0]  since_cons;
    logic         is_low;
    prior = cur_state;
    rate  = '0;
    case (f)
      FUNC_ADD_OPS: pending_ops = add_sat32(pending_ops, ops);
      FUNC_EVAL: begin
        hist_time[hist_head] = now;
        hist_ops[hist_head]  = pending_ops;
        pending_ops = '0;
        hist_head = (hist_head + 1) % HIST_DEPTH;
        if (hist_fill < HIST_DEPTH) hist_fill++;
        rate = window_rate(now);
        is_low = rate < {{(RATE_W-32){1'b0}}, low_thr};
        in_state = now - entry_time;
        case (prior)
          ACT_ACTIVE: if (is_low) begin
            cur_state  = ACT_LOW;
            entry_time = now;
          end
          ACT_LOW: if (!is_low) begin
            cur_state  = ACT_ACTIVE;
            entry_time = now;
          end else if (in_state >= min_sleep) begin
            cur_state  = ACT_SLEEP;
            entry_time = now;
          end
          default: if (!is_low) begin
            end_sleep(now);
          end
        endcase
      end
      FUNC_FORCE_SLEEP: begin
        cur_state  = ACT_SLEEP;
        entry_time = now;
      end
      FUNC_WAKE: if (cur_state == ACT_SLEEP) begin
        end_sleep(now);
      end
      FUNC_CONS_DONE: begin
        last_cons = now;
        cons_done = add_sat32(cons_done, 32'd1);
      end
      FUNC_CLEAR: begin
        periods   = '0;
        slept_s   = '0;
        cons_done = '0;
      end
      default: ;
    endcase
    since_cons      = now - last_cons;
    w.state         = cur_state;
    w.changed       = (f == FUNC_EVAL) && (cur_state != prior);
    w.rate          = rate;
    w.due           = auto_en && (cur_state == ACT_SLEEP) && (since_cons >= interval);
    w.sleep_periods = periods;
    w.sleep_secs    = slept_s;
    w.cons_cycles   = cons_done;
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr     = THR_RST;
      min_sleep   = MIN_SLEEP_RST;
      window      = WINDOW_RST;
      interval    = INTERVAL_RST;
      auto_en     = 1'b1;
      hist_head   = 0;
      hist_fill   = 0;
      pending_ops = '0;
      cur_state   = ACT_ACTIVE;
      entry_time  = '0;
      last_cons   = '0;
      periods     = '0;
      slept_s     = '0;
      cons_done   = '0;
      fail_count_o = 0;
      status_queue.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = status_word_t'(m_axis_tdata[OUT_BITS-1:0]);
        if (status_queue.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= REPORT_LIMIT) $display("unexpected result word %h", m_axis_tdata);
        end else begin
          want = status_queue.pop_front();
          if (got.state !== want.state || got.changed !== want.changed ||
              got.rate !== want.rate || got.due !== want.due ||
              got.sleep_periods !== want.sleep_periods ||
              got.sleep_secs !== want.sleep_secs || got.cons_cycles !== want.cons_cycles) begin
            fail_count_o++;
            if (fail_count_o <= REPORT_LIMIT) begin
              $display("mismatch (expected/actual): state %0d/%0d changed %0d/%0d rate %0d/%0d",
                       want.state, got.state, want.changed, got.changed, want.rate, got.rate);
              $display("  due %0d/%0d periods %0d/%0d seconds %0d/%0d consolidations %0d/%0d",
                       want.due, got.due, want.sleep_periods, got.sleep_periods,
                       want.sleep_secs, got.sleep_secs, want.cons_cycles, got.cons_cycles);
            end
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LOW_THR:   low_thr   = cfg_data_i;
          CFG_MIN_SLEEP: min_sleep = cfg_data_i;
          CFG_WINDOW:    window    = cfg_data_i;
          CFG_INTERVAL:  interval  = cfg_data_i;
          CFG_AUTO_EN:   auto_en   = cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predicted = apply_command(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]);
        status_queue.insert(status_queue.size(), predicted);
      end
    end
    pending_o = status_queue.size();
  end

endmodule

[sim/activity_sleep_state_controller_unit_tb.sv]
`timescale 1ns / 100ps
module activity_sleep_state_controller_unit_tb;
  import assc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT   = 20000;
  localparam int unsigned HOLD_OFF_CYCLES  = 3000;
  localparam int unsigned SETTLE_CYCLES    = 40;
  localparam int unsigned RANDOM_PER_PHASE = 92;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [FUNC_W-1:0]      s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int unsigned fail_count;
  int unsigned pending_words;
  int unsigned idle_cycles;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  int unsigned sink_calm = 0;
  int unsigned send_calm = 0;
  int unsigned ops_scale = 30;
  bit          hold_req = 1'b0;
  bit          quiet = 1'b0;
  logic [31:0] wall_ms;

  activity_sleep_state_controller_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  activity_sleep_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending_words)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 120);
  endfunction

  task automatic send_word(input logic [FUNC_W-1:0] f, input logic [31:0] now,
                           input logic [31:0] ops);
    int unsigned gap;
    gap = 0;
    if (send_calm > 0) begin
      send_calm--;
    end else if ($urandom_range(0, 99) < 3) begin
      send_calm = $urandom_range(30, 200);
    end else if ($urandom_range(0, 99) < 35) begin
      gap = pick_gap();
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ops, now};
    s_axis_tuser  <= f;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  task automatic send_random();
    int unsigned pick;
    int unsigned r;
    logic [31:0] step;
    logic [31:0] ops;
    pick = $urandom_range(0, 99);
    r = $urandom_range(0, 99);
    step = (r < 70) ? $urandom_range(0, 3000) :
           (r < 95) ? $urandom_range(3000, 30000) : $urandom_range(30000, 200000);
    if ($urandom_range(0, 99) < 3) quiet = !quiet;
    wall_ms += step;
    if (pick < 35) begin
      r = $urandom_range(0, 99);
      ops = (r < 5) ? $urandom : (r < 15) ? 32'd0 :
            quiet ? $urandom_range(0, 1) : $urandom_range(0, ops_scale);
      send_word(FUNC_ADD_OPS, wall_ms, ops);
    end else if (pick < 75) begin
      send_word(FUNC_EVAL, wall_ms, $urandom);
    end else if (pick < 82) begin
      send_word(FUNC_FORCE_SLEEP, wall_ms, $urandom);
    end else if (pick < 89) begin
      send_word(FUNC_WAKE, wall_ms, $urandom);
    end else if (pick < 94) begin
      send_word(FUNC_CONS_DONE, wall_ms, $urandom);
    end else if (pick < 97) begin
      send_word(FUNC_CLEAR, wall_ms, $urandom);
    end else begin
      // time jump, anywhere in the 32-bit range
      wall_ms = $urandom;
      send_word(FUNC_EVAL, wall_ms, 32'd0);
    end
  endtask

  task automatic run_phase(input logic [31:0] thr, input logic [31:0] min_sleep,
                           input logic [31:0] win, input logic [31:0] intv,
                           input logic [31:0] auto_en, input bit with_hold);
    drain();
    write_reg(CFG_LOW_THR, thr);
    write_reg(CFG_MIN_SLEEP, min_sleep);
    write_reg(CFG_WINDOW, win);
    write_reg(CFG_INTERVAL, intv);
    write_reg(CFG_AUTO_EN, auto_en);
    cfg_we_i <= 1'b0;
    ops_scale = $urandom_range(10, 80);
    if (with_hold) hold_req = 1'b1;
    repeat (RANDOM_PER_PHASE) send_random();
  endtask

  // result side back-pressure
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (sink_calm > 0) begin
          sink_calm--;
        end else if ($urandom_range(0, 99) < 4) begin
          sink_calm = $urandom_range(50, 400);
        end else if ($urandom_range(0, 99) < 35) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, reset configuration
    send_word(FUNC_ADD_OPS, 32'd0, 32'hFFFF_FFFF);
    send_word(FUNC_ADD_OPS, 32'd0, 32'd5);
    send_word(FUNC_EVAL, 32'd1000, 32'd0);
    send_word(FUNC_EVAL, 32'd2500, 32'd0);
    send_word(FUNC_FORCE_SLEEP, 32'd3000, 32'd0);
    send_word(FUNC_FORCE_SLEEP, 32'd4000, 32'd0);
    send_word(FUNC_WAKE, 32'd7500, 32'd0);
    send_word(FUNC_WAKE, 32'd8000, 32'd0);
    send_word(FUNC_CONS_DONE, 32'd9000, 32'd0);
    send_word(FUNC_SPARE_6, 32'd9100, 32'hFFFF_FFFF);
    send_word(FUNC_SPARE_7, 32'd9200, 32'd0);
    send_word(FUNC_CLEAR, 32'd9300, 32'd0);
    send_word(FUNC_EVAL, 32'hFFFF_FFFF, 32'd0);
    send_word(FUNC_ADD_OPS, 32'd0, 32'd3);
    send_word(FUNC_EVAL, 32'd4096, 32'd0);
    send_word(FUNC_EVAL, 32'd70000, 32'd0);
    send_word(FUNC_ADD_OPS, 32'd320000, 32'd1000000);
    send_word(FUNC_EVAL, 32'd322000, 32'd0);
    send_word(FUNC_EVAL, 32'd325000, 32'd0);
    send_word(FUNC_CONS_DONE, 32'd326000, 32'd0);
    send_word(FUNC_CLEAR, 32'h8000_0000, 32'd0);

    wall_ms = 32'h8000_0000;
    run_phase(32'd256, 32'd20000, 32'd30000, 32'd60000, 32'd1, 1'b0);
    run_phase(32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 1'b1);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0);
    run_phase($urandom_range(0, 2000), $urandom_range(0, 40000), $urandom_range(1000, 120000),
              $urandom_range(0, 200000), $urandom, 1'b0);
    run_phase(32'd512, 32'd5000, 32'd60000, 32'd20000, 32'd1, 1'b0);
    run_phase($urandom_range(0, 2000), $urandom_range(0, 40000), $urandom_range(1000, 120000),
              $urandom_range(0, 200000), $urandom, 1'b0);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_words == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
